[src/tcgr_pkg.sv]
package tcgr_pkg;

	// Text grid geometry
	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int GLYPH_HEIGHT = 16;
	localparam int CHARACTERS   = 256;
	localparam int CELL_WIDTH   = 8;

	localparam int GRID_W_PX = COLUMNS * CELL_WIDTH;
	localparam int GRID_H_PX = ROWS * GLYPH_HEIGHT;

	// Field widths
	localparam int CODE_W  = 8;
	localparam int ADDR_W  = 12;
	localparam int BYTE_W  = 8;
	localparam int COORD_W = 12;
	localparam int COLOR_W = 24;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 2;

	localparam int STORE_DEPTH = 4096;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS + 1);
	localparam int GROW_W = $clog2(GLYPH_HEIGHT);

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 56;

	localparam int QUEUE_DEPTH = 4;

	// Character codes
	localparam logic [CODE_W-1:0] CODE_LF = 8'h0a;
	localparam logic [CODE_W-1:0] CODE_CR = 8'h0d;

	// Register reset values
	localparam logic [COORD_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'd400;
	localparam logic [COLOR_W-1:0] COLOR_RESET  = 24'hffffff;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR  = 2'd2;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_DRAW  = 1'b1
	} op_t;

	// One queued command from the front to the back
	typedef struct packed {
		op_t               op;
		logic [CODE_W-1:0] code;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] glyph_byte;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] height;
		logic [COLOR_W-1:0] color;
	} cfg_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_DRAW = 2'b10
	} back_state_t;

endpackage

[src/tcgr_ram.sv]
module tcgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/tcgr_fifo.sv]
module tcgr_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcgr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output tcgr_pkg::cmd_t head,
	output logic          empty
);

	localparam int PTR_W = $clog2(tcgr_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(tcgr_pkg::QUEUE_DEPTH + 1);

	tcgr_pkg::cmd_t   entry_q [tcgr_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(tcgr_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/tcgr_front.sv]
module tcgr_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            in_func,
	input  logic [tcgr_pkg::S_TDATA_W-1:0]  in_data,
	output logic                            push,
	output tcgr_pkg::cmd_t                  push_cmd,
	input  logic                            queue_full
);

	logic [tcgr_pkg::COL_W-1:0] col_q;
	logic [tcgr_pkg::ROW_W-1:0] row_q;
	logic                       accept;
	logic                       grid_full;
	logic                       newline;
	tcgr_pkg::op_t              op;
	logic [tcgr_pkg::CODE_W-1:0] code;

	assign op        = tcgr_pkg::op_t'(in_func);
	assign code      = in_data[tcgr_pkg::CODE_W-1:0];
	assign in_ready  = !queue_full;
	assign accept    = in_valid && in_ready;
	assign grid_full = (row_q >= tcgr_pkg::ROW_W'(tcgr_pkg::ROWS));
	assign newline   = (code == tcgr_pkg::CODE_LF) || (code == tcgr_pkg::CODE_CR);

	// Drop characters once the grid is full, and new lines after moving the cursor
	assign push = accept && ((op == tcgr_pkg::OP_WRITE) || (!grid_full && !newline));

	always_comb begin
		push_cmd.op         = op;
		push_cmd.code       = code;
		push_cmd.addr       = in_data[tcgr_pkg::CODE_W +: tcgr_pkg::ADDR_W];
		push_cmd.glyph_byte = in_data[tcgr_pkg::CODE_W + tcgr_pkg::ADDR_W +: tcgr_pkg::BYTE_W];
		push_cmd.col        = col_q;
		push_cmd.row        = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && (op == tcgr_pkg::OP_DRAW) && !grid_full) begin
			if (newline || (col_q == tcgr_pkg::COL_W'(tcgr_pkg::COLUMNS - 1))) begin
				col_q <= '0;
				row_q <= row_q + tcgr_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + tcgr_pkg::COL_W'(1);
			end
		end
	end

endmodule

[src/tcgr_back.sv]
module tcgr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tcgr_pkg::cfg_t                 cfg,
	input  logic                           queue_empty,
	input  tcgr_pkg::cmd_t                 head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tcgr_pkg::M_TDATA_W-1:0] out_data,
	output logic                           out_last
);

	localparam int AW = $clog2(tcgr_pkg::STORE_DEPTH);
	localparam int CW = tcgr_pkg::COORD_W;

	tcgr_pkg::back_state_t state_q;
	logic [tcgr_pkg::GROW_W-1:0] grow_q;
	logic [tcgr_pkg::CODE_W-1:0] code_q;
	logic [CW-1:0] px_q;
	logic [CW-1:0] py_q;

	logic          valid_s1;
	logic [CW-1:0] x_s1;
	logic [CW-1:0] y_s1;
	logic          last_s1;

	logic                          out_valid_q;
	logic [CW-1:0]                 x_q;
	logic [CW-1:0]                 y_q;
	logic [tcgr_pkg::BYTE_W-1:0]   mask_q;
	logic [tcgr_pkg::COLOR_W-1:0]  color_q;
	logic                          last_q;

	logic [CW-1:0] x0;
	logic [CW-1:0] y0;
	logic [CW-1:0] px_d;
	logic [CW-1:0] py_d;
	logic          out_free;
	logic          adv;
	logic          issue;
	logic          ram_we;
	logic [AW-1:0] raddr;
	logic [tcgr_pkg::BYTE_W-1:0] rdata;

	// Centre the grid; a screen smaller than the grid puts it at the origin
	assign x0 = (cfg.width >= CW'(tcgr_pkg::GRID_W_PX))
		? ((cfg.width - CW'(tcgr_pkg::GRID_W_PX)) >> 1) : '0;
	assign y0 = (cfg.height >= CW'(tcgr_pkg::GRID_H_PX))
		? ((cfg.height - CW'(tcgr_pkg::GRID_H_PX)) >> 1) : '0;
	assign px_d = x0 + CW'(head.col) * CW'(tcgr_pkg::CELL_WIDTH);
	assign py_d = y0 + CW'(head.row) * CW'(tcgr_pkg::GLYPH_HEIGHT);

	assign pop      = (state_q == tcgr_pkg::BK_IDLE) && !queue_empty;
	assign ram_we   = pop && (head.op == tcgr_pkg::OP_WRITE);
	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && out_free;
	assign issue    = (state_q == tcgr_pkg::BK_DRAW) && (!valid_s1 || adv);
	assign raddr    = AW'(code_q) * AW'(tcgr_pkg::GLYPH_HEIGHT) + AW'(grow_q);

	tcgr_ram #(
		.WIDTH(tcgr_pkg::BYTE_W),
		.DEPTH(tcgr_pkg::STORE_DEPTH)
	) u_glyph_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(head.addr),
		.wdata(head.glyph_byte),
		.re   (issue),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcgr_pkg::BK_IDLE;
			grow_q  <= '0;
		end else begin
			unique case (state_q)
				tcgr_pkg::BK_IDLE: begin
					grow_q <= '0;
					if (pop && (head.op == tcgr_pkg::OP_DRAW)) begin
						state_q <= tcgr_pkg::BK_DRAW;
					end
				end
				tcgr_pkg::BK_DRAW: begin
					if (issue) begin
						grow_q <= grow_q + tcgr_pkg::GROW_W'(1);
						if (grow_q == tcgr_pkg::GROW_W'(tcgr_pkg::GLYPH_HEIGHT - 1)) begin
							state_q <= tcgr_pkg::BK_IDLE;
						end
					end
				end
				default: state_q <= tcgr_pkg::BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			code_q <= head.code;
			px_q   <= px_d;
			py_q   <= py_d;
		end
		if (issue) begin
			x_s1    <= px_q;
			y_s1    <= py_q + CW'(grow_q);
			last_s1 <= (grow_q == tcgr_pkg::GROW_W'(tcgr_pkg::GLYPH_HEIGHT - 1));
		end
		if (adv) begin
			x_q     <= x_s1;
			y_q     <= y_s1;
			mask_q  <= rdata;
			color_q <= cfg.color;
			last_q  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {color_q, mask_q, y_q, x_q};
	assign out_last  = last_q;

endmodule

[src/text_console_glyph_renderer_top.sv]
// Text console glyph renderer: draws 8x16 bitmap glyphs of an 80 by 25
// text grid, centred on a framebuffer, as one result per glyph row.
//
// Input stream (s_*): s_tuser selects the command, 0 loads one byte of the
// glyph store, 1 puts a character at the cursor. Line feed and carriage
// return move the cursor to the start of the next row and give no output;
// once the cursor has passed the last cell, characters are dropped.
// Output stream (m_*): sixteen transfers per drawn character, each with the
// row's pixel coordinates, paint mask and colour; m_tlast marks the last.
//
// In the back end a drawn character first sets up the cell position, then
// reads the glyph store once per row; a store write is written to the glyph
// store as it leaves the queue. A drawn row passes the read stage and the
// output register. The glyph RAM read, one per row, sets the rate.
// A four-entry command queue parts the input side from the drawing side.
// When m_tready is low the output register and one read stage hold, and the
// queue keeps taking input until full. Reset clears the cursor, the queue
// and the output valid flag and loads the register defaults; the glyph store keeps
// whatever it held and must be loaded before use. The user must write
// registers only while the block is idle; the block does not enforce it.
module text_console_glyph_renderer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [7:0] char_code, [19:8] glyph_address, [27:20] glyph_byte, [31:28] zero
	input  logic [tcgr_pkg::S_TDATA_W-1:0]    s_tdata,
	// [0] func
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [11:0] pixel_x, [23:12] pixel_y, [31:24] row_mask, [55:32] pixel_color
	output logic [tcgr_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [tcgr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcgr_pkg::CFG_W-1:0]        cfg_data
);

	tcgr_pkg::cfg_t cfg_q;
	tcgr_pkg::cmd_t push_cmd;
	tcgr_pkg::cmd_t head;
	logic push;
	logic pop;
	logic queue_full;
	logic queue_empty;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= tcgr_pkg::WIDTH_RESET;
			cfg_q.height <= tcgr_pkg::HEIGHT_RESET;
			cfg_q.color  <= tcgr_pkg::COLOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcgr_pkg::REG_WIDTH:  cfg_q.width  <= cfg_data[tcgr_pkg::COORD_W-1:0];
				tcgr_pkg::REG_HEIGHT: cfg_q.height <= cfg_data[tcgr_pkg::COORD_W-1:0];
				tcgr_pkg::REG_COLOR:  cfg_q.color  <= cfg_data[tcgr_pkg::COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: accept, track the cursor, classify
	tcgr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.in_data   (s_tdata),
		.push      (push),
		.push_cmd  (push_cmd),
		.queue_full(queue_full)
	);

	tcgr_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (queue_full),
		.pop     (pop),
		.head    (head),
		.empty   (queue_empty)
	);

	// Back: store writes and glyph row drawing
	tcgr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.queue_empty(queue_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_last   (m_tlast)
	);

endmodule

[src/tcgr_checker.sv]
module tcgr_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [tcgr_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                           m_tlast
);

	localparam int CW = tcgr_pkg::COORD_W;

	logic          in_glyph_q;
	logic [CW-1:0] prev_x_q;
	logic [CW-1:0] prev_y_q;
	logic [tcgr_pkg::COLOR_W-1:0] prev_color_q;
	logic          xfer;

	assign xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_glyph_q <= 1'b0;
		end else if (xfer) begin
			in_glyph_q <= !m_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			prev_x_q     <= m_tdata[CW-1:0];
			prev_y_q     <= m_tdata[2*CW-1:CW];
			prev_color_q <= m_tdata[tcgr_pkg::M_TDATA_W-1 -: tcgr_pkg::COLOR_W];
		end
	end

	// No output offered while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	// Rows of one glyph share x and colour and step down one line at a time
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && in_glyph_q |->
			m_tdata[CW-1:0] == prev_x_q &&
			m_tdata[2*CW-1:CW] == prev_y_q + CW'(1) &&
			m_tdata[tcgr_pkg::M_TDATA_W-1 -: tcgr_pkg::COLOR_W] == prev_color_q)
		else $error("glyph rows out of step");

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind text_console_glyph_renderer_top tcgr_checker u_tcgr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

[dv/testbench.sv]
`timescale 1ns / 1ps

// Glyph renderer bench. A predictor mirrors the font store, the cursor and the
// register bank, and turns every accepted input transfer into the glyph rows
// it should produce. A monitor pops those rows in order and compares them
// with each output transfer.
module testbench;
	import tcgr_pkg::*;

	// Timing of the bench
	localparam int DRAIN_CYCLES = 32;   // covers queued writes and line breaks
	localparam int QUIET_LIMIT  = 4000; // cycles without any transfer
	localparam int PHASE_ITEMS  = 20;

	// Screen geometry in cells
	localparam int CELLS = COLUMNS * ROWS;

	// Register index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// One glyph row as seen on the output stream
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [BYTE_W-1:0]  mask;
		logic [COLOR_W-1:0] color;
		logic               last;
	} glyph_row_t;

	// One line of the opening script; the first row is typed in where the
	// answer is obvious from the reset geometry
	typedef struct packed {
		op_t                op;
		logic [CODE_W-1:0]  code;
		logic [ADDR_W-1:0]  addr;
		logic [BYTE_W-1:0]  gbyte;
		logic               typed;
		glyph_row_t         first_row;
	} script_line_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b1;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tlast;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	// Mirror of the block
	logic [BYTE_W-1:0]      font_mirror [STORE_DEPTH];
	bit                     font_loaded [STORE_DEPTH];
	bit                     drawable [CHARACTERS];
	logic [CODE_W-1:0]      draw_codes [$];
	logic [10:0]            cursor = '0;
	logic [COORD_W-1:0]     scr_w = WIDTH_RESET;
	logic [COORD_W-1:0]     scr_h = HEIGHT_RESET;
	logic [COLOR_W-1:0]     ink = COLOR_RESET;

	// Glyph rows still owed by the block, oldest first
	glyph_row_t             rows_due [$];
	glyph_row_t             fresh_rows [GLYPH_HEIGHT];

	int                     send_idle_pct = 0;
	int                     recv_stall_pct = 0;
	int                     err_count = 0;
	int                     rows_checked = 0;
	int                     n_items = 0;
	int                     n_glyphs = 0;
	int                     n_writes = 0;
	int                     n_breaks = 0;
	int                     n_dropped = 0;
	int                     n_settings = 1;
	int                     quiet_cycles = 0;

	text_console_glyph_renderer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Work out what one accepted input transfer does to the mirror and fill
	// fresh_rows with the glyph rows it owes; return how many
	function automatic int forecast_glyph_rows(input op_t op, input logic [CODE_W-1:0] code,
			input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] gbyte);
		int unsigned x0;
		int unsigned y0;
		int unsigned glyph;
		bit          complete;
		int          n;
		n = 0;
		if (op == OP_WRITE) begin
			font_mirror[addr] = gbyte;
			font_loaded[addr] = 1'b1;
			n_writes++;
			// a code becomes drawable once all of its rows are loaded
			glyph = addr / GLYPH_HEIGHT;
			if (!drawable[glyph]) begin
				complete = 1'b1;
				for (int r = 0; r < GLYPH_HEIGHT; r++)
					if (!font_loaded[glyph * GLYPH_HEIGHT + r])
						complete = 1'b0;
				if (complete) begin
					drawable[glyph] = 1'b1;
					draw_codes.push_back(CODE_W'(glyph));
				end
			end
		end else if (cursor >= CELLS) begin
			// off the end of the screen: drop silently
			n_dropped++;
		end else if (code == CODE_LF || code == CODE_CR) begin
			cursor = 11'(cursor - cursor % COLUMNS + COLUMNS);
			n_breaks++;
		end else begin
			// centre the grid; a screen smaller than the grid pins it to 0
			x0 = (scr_w < GRID_W_PX) ? 0 : (scr_w - GRID_W_PX) / 2;
			y0 = (scr_h < GRID_H_PX) ? 0 : (scr_h - GRID_H_PX) / 2;
			for (int r = 0; r < GLYPH_HEIGHT; r++) begin
				fresh_rows[r].x     = COORD_W'(x0 + (cursor % COLUMNS) * CELL_WIDTH);
				fresh_rows[r].y     = COORD_W'(y0 + (cursor / COLUMNS) * GLYPH_HEIGHT + r);
				fresh_rows[r].mask  = font_mirror[code * GLYPH_HEIGHT + r];
				fresh_rows[r].color = ink;
				fresh_rows[r].last  = (r == GLYPH_HEIGHT - 1);
			end
			n = GLYPH_HEIGHT;
			cursor = cursor + 11'd1;
			n_glyphs++;
		end
		return n;
	endfunction

	// Offer one input transfer, with a random run of idle cycles first, and
	// book its glyph rows once it is accepted. Enter and leave at a falling edge.
	task automatic push_item(input op_t op, input logic [CODE_W-1:0] code,
			input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] gbyte,
			input logic typed, input glyph_row_t first_row);
		int n;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, gbyte, addr, code};
		do @(posedge clk); while (!s_tready);
		n_items++;
		n = forecast_glyph_rows(op, code, addr, gbyte);
		// a typed first row stands in for the forecast one
		if (typed && n > 0)
			fresh_rows[0] = first_row;
		for (int r = 0; r < n; r++)
			rows_due.push_back(fresh_rows[r]);
		@(negedge clk);
	endtask

	task automatic push_draw(input logic [CODE_W-1:0] code);
		push_item(OP_DRAW, code, ADDR_W'($urandom), BYTE_W'($urandom), 1'b0, '0);
	endtask

	task automatic push_write(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] gbyte);
		push_item(OP_WRITE, CODE_W'($urandom), addr, gbyte, 1'b0, '0);
	endtask

	task automatic push_break();
		push_draw($urandom_range(1) ? CODE_LF : CODE_CR);
	endtask

	task automatic draw_any_loaded();
		push_draw(draw_codes[$urandom_range(draw_codes.size() - 1)]);
	endtask

	// Drop valid, wait until every owed row has arrived and let queued
	// writes and line breaks drain
	task automatic settle();
		s_tvalid <= 1'b0;
		while (rows_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Drive one register write and wait for the next falling edge; the caller lowers cfg_we after
	// the last write of a batch
	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_WIDTH:  scr_w = val[COORD_W-1:0];
			REG_HEIGHT: scr_h = val[COORD_W-1:0];
			REG_COLOR:  ink   = val[COLOR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Receiver: stall at random, re-decided every falling edge
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// Monitor: compare each output transfer with the oldest owed row
	always @(posedge clk) begin : row_check
		glyph_row_t got;
		glyph_row_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.x     = m_tdata[11:0];
			got.y     = m_tdata[23:12];
			got.mask  = m_tdata[31:24];
			got.color = m_tdata[55:32];
			got.last  = m_tlast;
			if (rows_due.size() == 0) begin
				err_count++;
				$display("%0t: unexpected glyph row x=%0d y=%0d mask=%02h colour=%06h last=%0b",
					$time, got.x, got.y, got.mask, got.color, got.last);
			end else begin
				want = rows_due.pop_front();
				rows_checked++;
				if (got.x !== want.x || got.y !== want.y || got.mask !== want.mask ||
						got.color !== want.color || got.last !== want.last) begin
					err_count++;
					$display("%0t: row mismatch, expected x=%0d y=%0d mask=%02h colour=%06h last=%0b",
						$time, want.x, want.y, want.mask, want.color, want.last);
					$display("%0t: row mismatch, got      x=%0d y=%0d mask=%02h colour=%06h last=%0b",
						$time, got.x, got.y, got.mask, got.color, got.last);
				end
			end
		end
	end

	// Watchdog: give up after a long stretch with no transfer on any port
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d rows still owed",
					$time, quiet_cycles, rows_due.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin : stimulus
		script_line_t script [15];
		logic [BYTE_W-1:0] stripe [4];
		logic [CODE_W-1:0] code;
		int budget;
		int sel;

		// Hold reset, then release it at a falling edge
		arst_n <= 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Load two fonts whose rows sweep the mask extremes: code 0x00 from
		// address 0 and code 0xff up to the top address
		stripe = '{8'h00, 8'hff, 8'h80, 8'h01};
		for (int r = 0; r < GLYPH_HEIGHT; r++) begin
			push_write(ADDR_W'(r), stripe[r % 4]);
			push_write(ADDR_W'(8'hff * GLYPH_HEIGHT + r), stripe[(r + 1) % 4]);
		end

		// Opening script at reset geometry, so the grid origin is 0,0
		script = '{
			'{OP_DRAW,  8'h00, 12'h000, 8'h00, 1'b1, '{12'd0, 12'd0,  8'h00, COLOR_RESET, 1'b0}},
			'{OP_DRAW,  8'hff, 12'hfff, 8'hff, 1'b1, '{12'd8, 12'd0,  8'hff, COLOR_RESET, 1'b0}},
			'{OP_DRAW,  CODE_CR, 12'h000, 8'h00, 1'b0, '0},
			'{OP_DRAW,  8'hff, 12'h000, 8'h00, 1'b1, '{12'd0, 12'd16, 8'hff, COLOR_RESET, 1'b0}},
			'{OP_DRAW,  CODE_LF, 12'hfff, 8'hff, 1'b0, '0},
			// rewrite a row and draw it straight after
			'{OP_WRITE, 8'hff, 12'h000, 8'h5a, 1'b0, '0},
			'{OP_DRAW,  8'h00, 12'h000, 8'h00, 1'b1, '{12'd0, 12'd32, 8'h5a, COLOR_RESET, 1'b0}},
			'{OP_WRITE, 8'h00, 12'hfff, 8'ha5, 1'b0, '0},
			'{OP_DRAW,  8'hff, 12'h000, 8'h00, 1'b0, '0},
			// a write whose code field holds a line break must not move the cursor
			'{OP_WRITE, CODE_LF, 12'h001, 8'h3c, 1'b0, '0},
			'{OP_DRAW,  8'h00, 12'h000, 8'h00, 1'b0, '0},
			'{OP_DRAW,  CODE_LF, 12'h000, 8'h00, 1'b0, '0},
			// line break on an empty row still skips a row
			'{OP_DRAW,  CODE_LF, 12'h000, 8'h00, 1'b0, '0},
			'{OP_DRAW,  CODE_CR, 12'h000, 8'h00, 1'b0, '0},
			'{OP_DRAW,  8'h00, 12'h000, 8'h00, 1'b1, '{12'd0, 12'd80, 8'h5a, COLOR_RESET, 1'b0}}
		};
		foreach (script[i])
			push_item(script[i].op, script[i].code, script[i].addr, script[i].gbyte,
				script[i].typed, script[i].first_row);

		// Random phases, each under its own register setting and idle pattern
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: begin
					// largest screen, black ink; sender mostly idle
					program_reg(REG_WIDTH, CFG_W'(12'hfff));
					program_reg(REG_HEIGHT, CFG_W'(12'hfff));
					program_reg(REG_COLOR, '0);
					send_idle_pct = 81;
					recv_stall_pct = 0;
				end
				1: begin
					// screen smaller than the grid, plus a write to no register
					program_reg(REG_WIDTH, CFG_W'($urandom_range(GRID_W_PX - 1)));
					program_reg(REG_HEIGHT, CFG_W'($urandom_range(GRID_H_PX - 1)));
					program_reg(REG_COLOR, CFG_W'($urandom));
					program_reg(REG_SPARE, CFG_W'($urandom));
					send_idle_pct = 0;
					recv_stall_pct = 81;
				end
				2: begin
					// smallest legal screen, white ink written explicitly
					program_reg(REG_WIDTH, CFG_W'(GRID_W_PX));
					program_reg(REG_HEIGHT, CFG_W'(GRID_H_PX));
					program_reg(REG_COLOR, CFG_W'(24'hffffff));
					send_idle_pct = 13;
					recv_stall_pct = 13;
				end
				default: begin
					// random screen; junk in the unused upper data bits
					program_reg(REG_WIDTH,
						{12'($urandom), 12'($urandom_range(4095, GRID_W_PX))});
					program_reg(REG_HEIGHT,
						{12'($urandom), 12'($urandom_range(4095, GRID_H_PX))});
					program_reg(REG_COLOR, CFG_W'($urandom));
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			cfg_we <= 1'b0;
			n_settings++;

			budget = 0;
			while (budget < PHASE_ITEMS) begin
				sel = $urandom_range(99);
				if (sel < 10) begin
					// load a whole glyph, then it may be drawn
					code = CODE_W'($urandom);
					for (int r = 0; r < GLYPH_HEIGHT; r++)
						push_write(ADDR_W'(code * GLYPH_HEIGHT + r), BYTE_W'($urandom));
					budget += GLYPH_HEIGHT;
				end else if (sel < 20 && cursor / COLUMNS < 20) begin
					// keep a few rows free for the closing stretch
					push_break();
					budget++;
				end else if (sel < 45) begin
					push_write(ADDR_W'($urandom), BYTE_W'($urandom));
					budget++;
				end else begin
					draw_any_loaded();
					budget++;
				end
			end
		end

		// Closing stretch: break down to the last row, draw a few cells there,
		// break past the final cell, then check that nothing is drawn any more
		send_idle_pct = 13;
		recv_stall_pct = 13;
		while (cursor < CELLS - COLUMNS)
			push_break();
		repeat (4)
			if (cursor < CELLS)
				draw_any_loaded();
		push_item(OP_DRAW, CODE_LF, '0, '0, 1'b0, '0);
		push_item(OP_DRAW, CODE_CR, '0, '0, 1'b0, '0);
		repeat (6) begin
			if ($urandom_range(1))
				push_draw(CODE_W'($urandom));
			else
				push_write(ADDR_W'($urandom), BYTE_W'($urandom));
		end

		settle();
		$display("Covered %0d input transfers: %0d glyphs, %0d writes, %0d breaks, %0d dropped",
			n_items, n_glyphs, n_writes, n_breaks, n_dropped);
		$display("Compared %0d glyph rows across %0d register settings and four idle patterns",
			rows_checked, n_settings);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
